// File: hw/rtl/dpsp_pkg.sv
// Shared types and constants of the dual pedal sensor plausibility check.
package dpsp_pkg;

	localparam int MARGIN_W = 12;
	localparam int DZ_W     = 11;
	localparam int TORQUE_W = 15;
	localparam int CAUSE_W  = 2;
	localparam int IDX_W    = 3;

	typedef enum logic [CAUSE_W-1:0] {
		CAUSE_NONE     = 2'd0,
		CAUSE_A_RANGE  = 2'd1,
		CAUSE_B_RANGE  = 2'd2,
		CAUSE_DISAGREE = 2'd3
	} cause_t;

	typedef enum logic [IDX_W-1:0] {
		REG_A_MIN     = 3'd0,
		REG_A_MAX     = 3'd1,
		REG_B_MIN     = 3'd2,
		REG_B_MAX     = 3'd3,
		REG_MARGIN    = 3'd4,
		REG_DEAD_ZONE = 3'd5,
		REG_FULL      = 3'd6,
		REG_AGREE     = 3'd7
	} reg_idx_t;

	// Whether a sensor's torque comes from the divider, and its torque when it does not.
	typedef struct packed {
		logic                use_div;
		logic [TORQUE_W-1:0] snap;
	} lane_t;

	typedef struct packed {
		cause_t cause;
		lane_t  lane;
	} ctl_t;

endpackage

// File: hw/rtl/dpsp_in_if.sv
// Stream channel carrying one pair of raw pedal sensor samples.
interface dpsp_in_if #(parameter int ADC_BITS = 12) ();
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] sample_a;
	logic [ADC_BITS-1:0] sample_b;

	modport source(output valid, sample_a, sample_b, input ready);
	modport sink(input valid, sample_a, sample_b, output ready);
endinterface

// File: hw/rtl/dpsp_out_if.sv
// Stream channel carrying one torque request word with its fault status.
interface dpsp_out_if ();
	logic        valid;
	logic        ready;
	logic [14:0] torque_request;
	logic        fault;
	logic [1:0]  fault_cause;

	modport source(output valid, torque_request, fault, fault_cause, input ready);
	modport sink(input valid, torque_request, fault, fault_cause, output ready);
endinterface

// File: hw/rtl/dual_pedal_sensor_plausibility.sv
// Top level of the dual pedal sensor plausibility check.
// Each accepted word holds one pair of raw pedal sensor readings and yields one
// result word after passing through one register stage for the range check and dead
// zone classification, one for the scaling multiply, fifteen for the divider
// that resolves one quotient bit per stage, and the result register. A new pair
// is taken every cycle; the whole pipeline holds while the result register is
// full and not taken, so samples.ready follows results.ready in the same cycle.
// Calibration registers are written through cfg_we, cfg_idx and cfg_data and
// must only change while no word is in flight.
module dual_pedal_sensor_plausibility #(
	parameter int ADC_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  dpsp_pkg::reg_idx_t    cfg_idx,
	input  logic [((ADC_BITS > dpsp_pkg::TORQUE_W) ? ADC_BITS : dpsp_pkg::TORQUE_W)-1:0]
	                              cfg_data,
	dpsp_in_if.sink               samples,
	dpsp_out_if.source            results
);
	import dpsp_pkg::*;

	localparam int NUM_W = ADC_BITS + TORQUE_W;
	localparam int CTL_W = $bits(ctl_t);
	localparam int LANE_W = $bits(lane_t);
	localparam logic [ADC_BITS-1:0] RESET_MAX = ADC_BITS'(4095);

	logic [ADC_BITS-1:0] a_min_q;
	logic [ADC_BITS-1:0] a_max_q;
	logic [ADC_BITS-1:0] b_min_q;
	logic [ADC_BITS-1:0] b_max_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [DZ_W-1:0]     dead_zone_q;
	logic [TORQUE_W-1:0] full_q;
	logic [TORQUE_W-1:0] agree_q;

	logic                adv;
	logic                vld_s2;
	logic [NUM_W-1:0]    num_a_s2;
	logic [NUM_W-1:0]    num_b_s2;
	logic [ADC_BITS-1:0] den_a_s2;
	logic [ADC_BITS-1:0] den_b_s2;
	ctl_t                ctl_a_s2;
	lane_t               lane_b_s2;
	logic                div_vld_a;
	logic                div_vld_b;
	logic [TORQUE_W-1:0] quo_a;
	logic [TORQUE_W-1:0] quo_b;
	logic [CTL_W-1:0]    tag_a;
	logic [LANE_W-1:0]   tag_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_min_q     <= '0;
			a_max_q     <= RESET_MAX;
			b_min_q     <= '0;
			b_max_q     <= RESET_MAX;
			margin_q    <= '0;
			dead_zone_q <= '0;
			full_q      <= '0;
			agree_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_A_MIN:     a_min_q     <= cfg_data[ADC_BITS-1:0];
				REG_A_MAX:     a_max_q     <= cfg_data[ADC_BITS-1:0];
				REG_B_MIN:     b_min_q     <= cfg_data[ADC_BITS-1:0];
				REG_B_MAX:     b_max_q     <= cfg_data[ADC_BITS-1:0];
				REG_MARGIN:    margin_q    <= cfg_data[MARGIN_W-1:0];
				REG_DEAD_ZONE: dead_zone_q <= cfg_data[DZ_W-1:0];
				REG_FULL:      full_q      <= cfg_data[TORQUE_W-1:0];
				REG_AGREE:     agree_q     <= cfg_data[TORQUE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv           = !results.valid || results.ready;
	assign samples.ready = adv;

	dpsp_front #(.ADC_BITS(ADC_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_vld      (samples.valid),
		.sample_a    (samples.sample_a),
		.sample_b    (samples.sample_b),
		.a_min       (a_min_q),
		.a_max       (a_max_q),
		.b_min       (b_min_q),
		.b_max       (b_max_q),
		.margin      (margin_q),
		.dead_zone   (dead_zone_q),
		.full_torque (full_q),
		.vld_s2      (vld_s2),
		.num_a_s2    (num_a_s2),
		.den_a_s2    (den_a_s2),
		.ctl_a_s2    (ctl_a_s2),
		.num_b_s2    (num_b_s2),
		.den_b_s2    (den_b_s2),
		.lane_b_s2   (lane_b_s2)
	);

	dpsp_div #(.NUM_W(NUM_W), .DEN_W(ADC_BITS), .Q_W(TORQUE_W), .TAG_W(CTL_W)) u_div_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s2),
		.in_num  (num_a_s2),
		.in_den  (den_a_s2),
		.in_tag  (ctl_a_s2),
		.out_vld (div_vld_a),
		.out_quo (quo_a),
		.out_tag (tag_a)
	);

	dpsp_div #(.NUM_W(NUM_W), .DEN_W(ADC_BITS), .Q_W(TORQUE_W), .TAG_W(LANE_W)) u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s2),
		.in_num  (num_b_s2),
		.in_den  (den_b_s2),
		.in_tag  (lane_b_s2),
		.out_vld (div_vld_b),
		.out_quo (quo_b),
		.out_tag (tag_b)
	);

	dpsp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.vld         (div_vld_a),
		.quo_a       (quo_a),
		.ctl_a       (ctl_t'(tag_a)),
		.quo_b       (quo_b),
		.lane_b      (lane_t'(tag_b)),
		.agree_limit (agree_q),
		.results     (results)
	);

	// Both divider lanes carry the same words in lockstep.
	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_a == div_vld_b)
		else $error("divider lanes out of step");

	// A word at the divider output is not dropped while the pipeline holds.
	a_hold_keeps_word: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld_a && !adv) |=> div_vld_a)
		else $error("word lost in divider during stall");

	// The fault flag and the cause code agree, and a fault carries no torque.
	a_fault_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> ((results.fault == (results.fault_cause != CAUSE_NONE))
			&& (!results.fault || (results.torque_request == '0))))
		else $error("fault flag, cause and torque disagree");

	// An accepted pair always leaves a word in the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> u_front.vld_s1 == 1'b1)
		else $error("accepted word did not enter the pipeline");

endmodule

// File: hw/rtl/dpsp_front.sv
// Range check, dead zone classification and scaling multiply for both sensors.
module dpsp_front #(
	parameter int ADC_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic [ADC_BITS-1:0]           sample_a,
	input  logic [ADC_BITS-1:0]           sample_b,
	input  logic [ADC_BITS-1:0]           a_min,
	input  logic [ADC_BITS-1:0]           a_max,
	input  logic [ADC_BITS-1:0]           b_min,
	input  logic [ADC_BITS-1:0]           b_max,
	input  logic [dpsp_pkg::MARGIN_W-1:0] margin,
	input  logic [dpsp_pkg::DZ_W-1:0]     dead_zone,
	input  logic [dpsp_pkg::TORQUE_W-1:0] full_torque,
	output logic                          vld_s2,
	output logic [ADC_BITS+dpsp_pkg::TORQUE_W-1:0] num_a_s2,
	output logic [ADC_BITS-1:0]           den_a_s2,
	output dpsp_pkg::ctl_t                ctl_a_s2,
	output logic [ADC_BITS+dpsp_pkg::TORQUE_W-1:0] num_b_s2,
	output logic [ADC_BITS-1:0]           den_b_s2,
	output dpsp_pkg::lane_t               lane_b_s2
);
	import dpsp_pkg::*;

	localparam int RW    = ((ADC_BITS > MARGIN_W) ? ADC_BITS : MARGIN_W) + 1;
	localparam int DW    = ((ADC_BITS > DZ_W) ? ADC_BITS : DZ_W) + 1;
	localparam int NUM_W = ADC_BITS + TORQUE_W;

	function automatic logic out_of_range(input logic [ADC_BITS-1:0] lo,
			input logic [ADC_BITS-1:0] hi, input logic [ADC_BITS-1:0] x,
			input logic [MARGIN_W-1:0] m);
		logic hi_bad;
		logic lo_bad;
		hi_bad = RW'(x) > (RW'(hi) + RW'(m));
		lo_bad = (RW'(lo) > RW'(m)) && (RW'(x) < (RW'(lo) - RW'(m)));
		return hi_bad || lo_bad;
	endfunction

	function automatic lane_t classify(input logic [ADC_BITS-1:0] lo,
			input logic [ADC_BITS-1:0] hi, input logic [ADC_BITS-1:0] x,
			input logic [DZ_W-1:0] dz, input logic [TORQUE_W-1:0] ft);
		lane_t r;
		logic  below;
		logic  above;
		below = DW'(x) < (DW'(lo) + DW'(dz));
		above = (DW'(x) + DW'(dz)) > DW'(hi);
		r.use_div = !below && !above && (hi > lo);
		r.snap    = (!below && above) ? ft : '0;
		return r;
	endfunction

	logic                vld_s1;
	cause_t              cause_s1;
	lane_t               lane_a_s1;
	lane_t               lane_b_s1;
	logic [ADC_BITS-1:0] diff_a_s1;
	logic [ADC_BITS-1:0] diff_b_s1;
	logic [ADC_BITS-1:0] span_a_s1;
	logic [ADC_BITS-1:0] span_b_s1;
	cause_t              cause_d;

	always_comb begin
		if (out_of_range(a_min, a_max, sample_a, margin)) begin
			cause_d = CAUSE_A_RANGE;
		end else if (out_of_range(b_min, b_max, sample_b, margin)) begin
			cause_d = CAUSE_B_RANGE;
		end else begin
			cause_d = CAUSE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cause_s1  <= cause_d;
			lane_a_s1 <= classify(a_min, a_max, sample_a, dead_zone, full_torque);
			lane_b_s1 <= classify(b_min, b_max, sample_b, dead_zone, full_torque);
			diff_a_s1 <= sample_a - a_min;
			diff_b_s1 <= sample_b - b_min;
			span_a_s1 <= a_max - a_min;
			span_b_s1 <= b_max - b_min;

			num_a_s2       <= NUM_W'(diff_a_s1) * NUM_W'(full_torque);
			num_b_s2       <= NUM_W'(diff_b_s1) * NUM_W'(full_torque);
			den_a_s2       <= span_a_s1;
			den_b_s2       <= span_b_s1;
			ctl_a_s2.cause <= cause_s1;
			ctl_a_s2.lane  <= lane_a_s1;
			lane_b_s2      <= lane_b_s1;
		end
	end

endmodule

// File: hw/rtl/dpsp_div.sv
// Pipelined restoring divider that resolves one quotient bit per stage.
module dpsp_div #(
	parameter int NUM_W = 27,
	parameter int DEN_W = 12,
	parameter int Q_W   = 15,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_vld,
	output logic [Q_W-1:0]   out_quo,
	output logic [TAG_W-1:0] out_tag
);

	logic             vld_s [Q_W+1];
	logic [NUM_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W+1];
	logic [TAG_W-1:0] tag_s [Q_W+1];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = in_num;
	assign den_s[0] = in_den;
	assign quo_s[0] = '0;
	assign tag_s[0] = in_tag;

	// The quotient is known to fit in Q_W bits, so stage i tries the divisor
	// shifted by Q_W-i places.
	for (genvar i = 1; i <= Q_W; i++) begin : g_stage
		logic [NUM_W-1:0] dsh;
		logic             ge;

		assign dsh = NUM_W'(den_s[i-1]) << (Q_W - i);
		assign ge  = rem_s[i-1] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s[i] <= {quo_s[i-1][Q_W-2:0], ge};
				tag_s[i] <= tag_s[i-1];
			end
		end

		if (i < Q_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i] <= ge ? (rem_s[i-1] - dsh) : rem_s[i-1];
					den_s[i] <= den_s[i-1];
				end
			end
		end
	end

	assign out_vld = vld_s[Q_W];
	assign out_quo = quo_s[Q_W];
	assign out_tag = tag_s[Q_W];

endmodule

// File: hw/rtl/dpsp_back.sv
// Agreement check between the two torques and the result word register.
module dpsp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          vld,
	input  logic [dpsp_pkg::TORQUE_W-1:0] quo_a,
	input  dpsp_pkg::ctl_t                ctl_a,
	input  logic [dpsp_pkg::TORQUE_W-1:0] quo_b,
	input  dpsp_pkg::lane_t               lane_b,
	input  logic [dpsp_pkg::TORQUE_W-1:0] agree_limit,
	dpsp_out_if.source                    results
);
	import dpsp_pkg::*;

	logic [TORQUE_W-1:0] ta;
	logic [TORQUE_W-1:0] tb;
	logic [TORQUE_W-1:0] gap;
	cause_t              cause_d;

	assign ta  = ctl_a.lane.use_div ? quo_a : ctl_a.lane.snap;
	assign tb  = lane_b.use_div ? quo_b : lane_b.snap;
	assign gap = (ta > tb) ? (ta - tb) : (tb - ta);

	always_comb begin
		if (ctl_a.cause != CAUSE_NONE) begin
			cause_d = ctl_a.cause;
		end else if (gap > agree_limit) begin
			cause_d = CAUSE_DISAGREE;
		end else begin
			cause_d = CAUSE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (adv) begin
			results.valid <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			results.torque_request <= (cause_d == CAUSE_NONE) ? ta : '0;
			results.fault          <= cause_d != CAUSE_NONE;
			results.fault_cause    <= cause_d;
		end
	end

endmodule
